// File: rtl/core/bsrpp_pkg.sv
// shared types and codes for the lifo byte stack
// operation kinds, status codes, transaction payload structs, default sizes
// no dependencies
package bsrpp_pkg;

  localparam int CNT_W  = 9;
  localparam int SIZE_W = 4;
  localparam int DATA_W = 64;

  localparam int DEFAULT_STORE_DEPTH      = 256;
  localparam int DEFAULT_MAX_RECORD_BYTES = 8;

  localparam logic [CNT_W-1:0] CAP_RESET = 9'd256;

  // operation kinds
  localparam logic [1:0] KIND_PUSH  = 2'd0;
  localparam logic [1:0] KIND_POP   = 2'd1;
  localparam logic [1:0] KIND_PEEK  = 2'd2;
  localparam logic [1:0] KIND_CLEAR = 2'd3;

  // status codes
  localparam logic [2:0] ST_OK    = 3'd0;
  localparam logic [2:0] ST_FULL  = 3'd1;
  localparam logic [2:0] ST_NOFIT = 3'd2;
  localparam logic [2:0] ST_EMPTY = 3'd3;
  localparam logic [2:0] ST_SHORT = 3'd4;

  typedef struct packed {
    logic [1:0]        kind;
    logic [SIZE_W-1:0] size;
    logic [DATA_W-1:0] push_data;
  } in_t;

  typedef struct packed {
    logic [2:0]        status;
    logic [DATA_W-1:0] read_data;
    logic [CNT_W-1:0]  fill_count;
    logic              is_full;
    logic              is_empty;
  } out_t;

endpackage

// File: rtl/core/bsrpp_ram.sv
// byte-wide single-port store for the lifo byte stack
// one access per cycle, registered read data; no package dependencies
module bsrpp_ram #(
  parameter int DEPTH = 256,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] addr,
  input  logic [7:0]    wdata,
  output logic [7:0]    rdata
);

  logic [7:0] mem [DEPTH];
  logic [7:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata_r <= mem[addr];
  end

  assign rdata = rdata_r;

endmodule

// File: rtl/core/bsrpp_seq.sv
// sequencer of the lifo byte stack: status checks, byte moves, count
// one shared 9-bit add/subtract unit serves the space check, byte moves and count; uses bsrpp_pkg
module bsrpp_seq #(
  parameter int STORE_DEPTH      = bsrpp_pkg::DEFAULT_STORE_DEPTH,
  parameter int MAX_RECORD_BYTES = bsrpp_pkg::DEFAULT_MAX_RECORD_BYTES,
  localparam int AW = $clog2(STORE_DEPTH)
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  bsrpp_pkg::in_t             in_data,
  input  logic [bsrpp_pkg::CNT_W-1:0] eff_cap,
  output logic                       res_valid,
  input  logic                       res_take,
  output bsrpp_pkg::out_t            res_data,
  output logic                       ram_we,
  output logic [AW-1:0]              ram_addr,
  output logic [7:0]                 ram_wdata,
  input  logic [7:0]                 ram_rdata
);

  localparam int CW = bsrpp_pkg::CNT_W;
  localparam int SW = bsrpp_pkg::SIZE_W;
  localparam logic [SW-1:0] MAXB = SW'(MAX_RECORD_BYTES);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_CHECK = 3'd1;
  localparam logic [2:0] S_PUSH  = 3'd2;
  localparam logic [2:0] S_READ  = 3'd3;
  localparam logic [2:0] S_DRAIN = 3'd4;
  localparam logic [2:0] S_DONE  = 3'd5;

  logic [2:0]                   state_r, state_nxt;
  logic [1:0]                   kind_r, kind_nxt;
  logic [SW-1:0]                n_r, n_nxt;
  logic [SW-1:0]                k_r, k_nxt;
  logic [bsrpp_pkg::DATA_W-1:0] data_r, data_nxt;
  logic [bsrpp_pkg::DATA_W-1:0] rd_r, rd_nxt;
  logic [CW-1:0]                ptr_r, ptr_nxt;
  logic [CW-1:0]                count_r, count_nxt;
  logic [2:0]                   status_r, status_nxt;
  logic                         cap_vld_r, cap_vld_nxt;
  logic [2:0]                   cap_idx_r, cap_idx_nxt;

  logic [SW-1:0] size_sat;
  logic          go;

  // shared add/subtract unit, bit CW is the borrow on subtract
  logic [CW-1:0] alu_a, alu_b;
  logic          alu_sub;
  logic [CW:0]   alu_res;

  assign alu_res = alu_sub ? ({1'b0, alu_a} - {1'b0, alu_b})
                           : ({1'b0, alu_a} + {1'b0, alu_b});

  assign size_sat  = (in_data.size > MAXB) ? MAXB : in_data.size;
  assign in_ready  = (state_r == S_IDLE);
  assign res_valid = (state_r == S_DONE);
  assign ram_wdata = data_r[7:0];

  always_comb begin
    state_nxt   = state_r;
    kind_nxt    = kind_r;
    n_nxt       = n_r;
    k_nxt       = k_r;
    data_nxt    = data_r;
    rd_nxt      = rd_r;
    ptr_nxt     = ptr_r;
    count_nxt   = count_r;
    status_nxt  = status_r;
    cap_vld_nxt = (state_r == S_READ);
    cap_idx_nxt = k_r[2:0];
    alu_a       = count_r;
    alu_b       = '0;
    alu_sub     = 1'b0;
    ram_we      = 1'b0;
    ram_addr    = AW'(count_r);
    go          = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          kind_nxt  = in_data.kind;
          n_nxt     = size_sat;
          data_nxt  = in_data.push_data;
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        // free space = capacity - count
        alu_a      = eff_cap;
        alu_b      = count_r;
        alu_sub    = 1'b1;
        k_nxt      = '0;
        ptr_nxt    = count_r;
        rd_nxt     = '0;
        status_nxt = bsrpp_pkg::ST_OK;
        unique case (kind_r) inside
          bsrpp_pkg::KIND_PUSH: begin
            if (alu_res[CW] || (alu_res[CW-1:0] == '0)) begin
              status_nxt = bsrpp_pkg::ST_FULL;
            end else if (alu_res[CW-1:0] < CW'(n_r)) begin
              status_nxt = bsrpp_pkg::ST_NOFIT;
            end else begin
              go = 1'b1;
            end
          end
          bsrpp_pkg::KIND_POP, bsrpp_pkg::KIND_PEEK: begin
            if (count_r == '0) begin
              status_nxt = bsrpp_pkg::ST_EMPTY;
            end else if (count_r < CW'(n_r)) begin
              status_nxt = bsrpp_pkg::ST_SHORT;
            end else begin
              go = 1'b1;
            end
          end
          bsrpp_pkg::KIND_CLEAR: begin
            count_nxt = '0;
          end
        endcase
        if (go && (n_r != '0)) begin
          state_nxt = (kind_r == bsrpp_pkg::KIND_PUSH) ? S_PUSH : S_READ;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_PUSH: begin
        // one byte per cycle onto the top
        ram_we    = 1'b1;
        ram_addr  = AW'(count_r);
        alu_a     = count_r;
        alu_b     = CW'(1);
        count_nxt = alu_res[CW-1:0];
        data_nxt  = data_r >> 8;
        k_nxt     = k_r + SW'(1);
        if (k_nxt == n_r) begin
          state_nxt = S_DONE;
        end
      end
      S_READ: begin
        // walk down from the top, one read issued per cycle
        alu_a    = ptr_r;
        alu_b    = CW'(1);
        alu_sub  = 1'b1;
        ram_addr = AW'(alu_res[CW-1:0]);
        ptr_nxt  = alu_res[CW-1:0];
        k_nxt    = k_r + SW'(1);
        if (k_nxt == n_r) begin
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: begin
        if (kind_r == bsrpp_pkg::KIND_POP) begin
          alu_a     = count_r;
          alu_b     = CW'(n_r);
          alu_sub   = 1'b1;
          count_nxt = alu_res[CW-1:0];
        end
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (res_take) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // read data lands in the cycle after its address
    if (cap_vld_r) begin
      rd_nxt[cap_idx_r*8 +: 8] = ram_rdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      count_r   <= '0;
      cap_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      count_r   <= count_nxt;
      cap_vld_r <= cap_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    kind_r    <= kind_nxt;
    n_r       <= n_nxt;
    k_r       <= k_nxt;
    data_r    <= data_nxt;
    rd_r      <= rd_nxt;
    ptr_r     <= ptr_nxt;
    status_r  <= status_nxt;
    cap_idx_r <= cap_idx_nxt;
  end

  always_comb begin
    res_data.status     = status_r;
    res_data.read_data  = rd_r;
    res_data.fill_count = count_r;
    res_data.is_full    = (count_r >= eff_cap);
    res_data.is_empty   = (count_r == '0);
  end

endmodule

// File: rtl/core/byte_stack_record_push_pop.sv
// sequence: a push goes through the check, then the byte writes, then the result;
// a pop or peek through the check, the byte reads and a data drain; a size of zero,
// an error or a clear goes from the check straight to the result; the block takes no
// new transaction until the output slot has taken the last result
// the single byte-wide store port moves one byte per cycle during the byte walk
// reset (synchronous, rst_n low): stack empty, capacity 256, output slot empty
module byte_stack_record_push_pop #(
  parameter int STORE_DEPTH      = bsrpp_pkg::DEFAULT_STORE_DEPTH,
  parameter int MAX_RECORD_BYTES = bsrpp_pkg::DEFAULT_MAX_RECORD_BYTES
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  bsrpp_pkg::in_t              in_data,
  output logic                        out_valid,
  input  logic                        out_ready,
  output bsrpp_pkg::out_t             out_data,
  input  logic                        cfg_wr_en,
  input  logic [bsrpp_pkg::CNT_W-1:0] cfg_wr_data
);

  localparam int CW = bsrpp_pkg::CNT_W;
  localparam int AW = $clog2(STORE_DEPTH);
  // capacity field can never exceed its own range, nor the store
  localparam int CapMaxInt = (STORE_DEPTH > ((1 << CW) - 1)) ? ((1 << CW) - 1)
                                                            : STORE_DEPTH;
  localparam logic [CW-1:0] CAP_MAX = CW'(CapMaxInt);

  // capacity register
  logic [CW-1:0] cfg_cap_r, cfg_cap_nxt;
  logic [CW-1:0] eff_cap;

  // output slot
  logic            out_valid_r, out_valid_nxt;
  bsrpp_pkg::out_t out_data_r, out_data_nxt;
  logic            out_free;

  // sequencer result
  logic            res_valid;
  bsrpp_pkg::out_t res_data;

  // store port
  logic          ram_we;
  logic [AW-1:0] ram_addr;
  logic [7:0]    ram_wdata;
  logic [7:0]    ram_rdata;

  assign cfg_cap_nxt = cfg_wr_en ? cfg_wr_data : cfg_cap_r;

  // zero acts as one, anything past the store acts as the store size
  always_comb begin
    if (cfg_cap_r == '0) begin
      eff_cap = CW'(1);
    end else if (cfg_cap_r > CAP_MAX) begin
      eff_cap = CAP_MAX;
    end else begin
      eff_cap = cfg_cap_r;
    end
  end

  // output slot takes a new result when empty or being drained this cycle
  assign out_free = !out_valid_r || out_ready;

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (res_valid && out_free) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = res_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_cap_r   <= bsrpp_pkg::CAP_RESET;
      out_valid_r <= 1'b0;
    end else begin
      cfg_cap_r   <= cfg_cap_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // control: checks, byte walk and fill count
  bsrpp_seq #(
    .STORE_DEPTH      (STORE_DEPTH),
    .MAX_RECORD_BYTES (MAX_RECORD_BYTES)
  ) u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .eff_cap   (eff_cap),
    .res_valid (res_valid),
    .res_take  (out_free),
    .res_data  (res_data),
    .ram_we    (ram_we),
    .ram_addr  (ram_addr),
    .ram_wdata (ram_wdata),
    .ram_rdata (ram_rdata)
  );

  // byte store, entries undefined until pushed
  bsrpp_ram #(
    .DEPTH (STORE_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

`ifndef SYNTHESIS
  // fill count stays within the largest usable capacity
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_data_r.fill_count <= CAP_MAX))
    else $error("fill count beyond capacity range");

  // an accepted transaction keeps the block busy on the next cycle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input ready right after accept");

  // failed operations return no data
  a_err_no_data: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_data_r.status != bsrpp_pkg::ST_OK))
      |-> (out_data_r.read_data == '0))
    else $error("read data on failed transaction");

  // empty flag agrees with the count
  a_empty_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_data_r.is_empty == (out_data_r.fill_count == '0)))
    else $error("empty flag mismatch");
`endif

endmodule

// File: sim/stack_result_checker.sv
// result checker for the lifo byte stack: watches the input, result and capacity ports,
// predicts each result from its own copy of the stack and compares it field by field
// depends on bsrpp_pkg
module stack_result_checker #(
  parameter int STORE_DEPTH      = bsrpp_pkg::DEFAULT_STORE_DEPTH,
  parameter int MAX_RECORD_BYTES = bsrpp_pkg::DEFAULT_MAX_RECORD_BYTES
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  input  logic                        in_ready,
  input  bsrpp_pkg::in_t              in_data,
  input  logic                        out_valid,
  input  logic                        out_ready,
  input  bsrpp_pkg::out_t             out_data,
  input  logic                        cfg_wr_en,
  input  logic [bsrpp_pkg::CNT_W-1:0] cfg_wr_data,
  output int                          fail_count,
  output int                          pending_count
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int REPORT_LIMIT = 10;

  logic [7:0]                  stack_mem [0:STORE_DEPTH-1];
  int                          stack_fill;
  logic [bsrpp_pkg::CNT_W-1:0] capacity_reg;
  bsrpp_pkg::out_t             expected_results [$];
  int                          mismatches;

  initial begin
    fail_count    = 0;
    pending_count = 0;
    mismatches    = 0;
    stack_fill    = 0;
    capacity_reg  = bsrpp_pkg::CAP_RESET;
  end

  // applies one operation to the local stack and returns the result it gives
  function automatic bsrpp_pkg::out_t apply_stack_op(input bsrpp_pkg::in_t op);
    bsrpp_pkg::out_t res;
    int              cap;
    int              n;
    cap = (capacity_reg == 0) ? 1 :
          (int'(capacity_reg) > STORE_DEPTH) ? STORE_DEPTH : int'(capacity_reg);
    n = (int'(op.size) > MAX_RECORD_BYTES) ? MAX_RECORD_BYTES : int'(op.size);
    res = '0;
    res.status = bsrpp_pkg::ST_OK;
    case (op.kind)
      bsrpp_pkg::KIND_PUSH: begin
        if (stack_fill >= cap) begin
          res.status = bsrpp_pkg::ST_FULL;
        end else if (cap - stack_fill < n) begin
          res.status = bsrpp_pkg::ST_NOFIT;
        end else begin
          for (int k = 0; k < n; k++) begin
            stack_mem[stack_fill] = op.push_data[8*k +: 8];
            stack_fill++;
          end
        end
      end
      bsrpp_pkg::KIND_POP, bsrpp_pkg::KIND_PEEK: begin
        if (stack_fill == 0) begin
          res.status = bsrpp_pkg::ST_EMPTY;
        end else if (stack_fill < n) begin
          res.status = bsrpp_pkg::ST_SHORT;
        end else begin
          // topmost byte lands in byte 0
          for (int k = 0; k < n; k++)
            res.read_data[8*k +: 8] = stack_mem[stack_fill-1-k];
          if (op.kind == bsrpp_pkg::KIND_POP)
            stack_fill -= n;
        end
      end
      default: begin
        stack_fill = 0;
      end
    endcase
    res.fill_count = stack_fill[bsrpp_pkg::CNT_W-1:0];
    res.is_full    = (stack_fill >= cap);
    res.is_empty   = (stack_fill == 0);
    return res;
  endfunction

  always @(posedge clk) begin
    bsrpp_pkg::out_t want;
    if (!rst_n) begin
      stack_fill   = 0;
      capacity_reg = bsrpp_pkg::CAP_RESET;
      expected_results.delete();
    end else begin
      if (cfg_wr_en)
        capacity_reg = cfg_wr_data;
      if (in_valid && in_ready)
        expected_results.push_back(apply_stack_op(in_data));
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          mismatches++;
          if (mismatches <= REPORT_LIMIT)
            $display("unexpected result: status %0d data %h count %0d",
                     out_data.status, out_data.read_data, out_data.fill_count);
        end else begin
          want = expected_results.pop_front();
          if (out_data.status !== want.status || out_data.read_data !== want.read_data ||
              out_data.fill_count !== want.fill_count ||
              out_data.is_full !== want.is_full || out_data.is_empty !== want.is_empty)
          begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT) begin
              $write("mismatch exp/act: status %0d/%0d data %h/%h count %0d/%0d",
                     want.status, out_data.status, want.read_data, out_data.read_data,
                     want.fill_count, out_data.fill_count);
              $display(" full %b/%b empty %b/%b", want.is_full, out_data.is_full,
                       want.is_empty, out_data.is_empty);
            end
          end
        end
      end
    end
    fail_count    <= mismatches;
    pending_count <= expected_results.size();
  end

endmodule

// File: sim/testbench.sv
// top of the lifo byte stack test: clock, reset, directed and random stimulus,
// receiver stalls, capacity writes between phases and the final verdict
// depends on bsrpp_pkg, byte_stack_record_push_pop and stack_result_checker
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT      = 200000;
  localparam int SETTLE_CYCLES    = 12;
  localparam int DRAIN_CYCLES     = 24;
  localparam int LONG_HOLD_CYCLES = 300;
  localparam int NUM_PHASES       = 14;
  localparam int ITEMS_PER_PHASE  = 125;

  logic                        clk         = 1'b0;
  logic                        rst_n       = 1'b0;
  logic                        in_valid    = 1'b0;
  logic                        in_ready;
  bsrpp_pkg::in_t              in_data     = '0;
  logic                        out_valid;
  logic                        out_ready   = 1'b0;
  bsrpp_pkg::out_t             out_data;
  logic                        cfg_wr_en   = 1'b0;
  logic [bsrpp_pkg::CNT_W-1:0] cfg_wr_data = '0;

  int err_count;
  int pending;
  int cycle_count = 0;

  // shared between sender and receiver: no-idle stretches and the long stall request
  bit burst_mode    = 1'b0;
  bit long_hold_req = 1'b0;

  // capacity per random phase: the extremes, out of range values and a few in between
  logic [bsrpp_pkg::CNT_W-1:0] phase_caps [0:NUM_PHASES-1] =
    '{9'd256, 9'd17, 9'd511, 9'd1, 9'd64, 9'd0, 9'd300,
      9'd5, 9'd256, 9'd128, 9'd9, 9'd256, 9'd2, 9'd200};

  byte_stack_record_push_pop uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  stack_result_checker checker_i (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_data      (in_data),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_data     (out_data),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data),
    .fail_count   (err_count),
    .pending_count(pending)
  );

  always #4 clk = ~clk;

  // watchdog against a hung handshake
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  function automatic bsrpp_pkg::in_t stack_op(
      input logic [1:0]                   kind,
      input logic [bsrpp_pkg::SIZE_W-1:0] size,
      input logic [bsrpp_pkg::DATA_W-1:0] data);
    bsrpp_pkg::in_t op;
    op.kind      = kind;
    op.size      = size;
    op.push_data = data;
    return op;
  endfunction

  // random operation; clears take two percent, pushes push_weight minus two percent
  function automatic bsrpp_pkg::in_t random_stack_op(input int push_weight);
    bsrpp_pkg::in_t op;
    int             roll;
    roll = $urandom_range(99);
    if (roll < 2)
      op.kind = bsrpp_pkg::KIND_CLEAR;
    else if (roll < push_weight)
      op.kind = bsrpp_pkg::KIND_PUSH;
    else if ($urandom_range(2) == 0)
      op.kind = bsrpp_pkg::KIND_PEEK;
    else
      op.kind = bsrpp_pkg::KIND_POP;
    // mostly legal sizes, now and then an oversized one that saturates
    if ($urandom_range(19) < 2)
      op.size = bsrpp_pkg::SIZE_W'($urandom_range(15, 9));
    else
      op.size = bsrpp_pkg::SIZE_W'($urandom_range(8));
    op.push_data = {$urandom, $urandom};
    return op;
  endfunction

  // one input transaction: random gap (none in burst mode), then hold valid until accepted;
  // valid stays high on return so a back-to-back transaction needs no toggle
  task automatic send_op(input bsrpp_pkg::in_t op);
    int gap;
    gap = burst_mode ? 0 : $urandom_range(7);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= op;
    do @(posedge clk); while (!in_ready);
  endtask

  // one edge first so the checker's count includes the last accepted transaction
  task automatic wait_drained();
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  // capacity writes happen only with the block idle
  task automatic write_capacity(input logic [bsrpp_pkg::CNT_W-1:0] value);
    in_valid <= 1'b0;
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  // receiver: random ready gaps, plus one long stall on request
  initial begin
    int wait_cycles;
    do @(posedge clk); while (!rst_n);
    forever begin
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        out_ready <= 1'b0;
        repeat (LONG_HOLD_CYCLES) @(posedge clk);
      end
      wait_cycles = burst_mode ? 0 : $urandom_range(7);
      if (wait_cycles > 0) begin
        out_ready <= 1'b0;
        repeat (wait_cycles) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  // stimulus
  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // directed part, capacity 256 from reset
    // empty stack: pop and zero-size peek both report empty
    send_op(stack_op(bsrpp_pkg::KIND_POP,  4'd1, 64'h0));
    send_op(stack_op(bsrpp_pkg::KIND_PEEK, 4'd0, 64'h0));
    // zero-size push succeeds and moves nothing
    send_op(stack_op(bsrpp_pkg::KIND_PUSH, 4'd0, '1));
    send_op(stack_op(bsrpp_pkg::KIND_PUSH, 4'd8, '1));
    send_op(stack_op(bsrpp_pkg::KIND_PUSH, 4'd8, 64'h0123_4567_89ab_cdef));
    send_op(stack_op(bsrpp_pkg::KIND_PEEK, 4'd8, 64'h0));
    // oversized sizes saturate to eight bytes
    send_op(stack_op(bsrpp_pkg::KIND_POP,  4'd15, '1));
    send_op(stack_op(bsrpp_pkg::KIND_PEEK, 4'd9, 64'h0));
    send_op(stack_op(bsrpp_pkg::KIND_POP,  4'd0, 64'h0));
    send_op(stack_op(bsrpp_pkg::KIND_POP,  4'd8, 64'h0));
    send_op(stack_op(bsrpp_pkg::KIND_POP,  4'd1, 64'h0));
    // not enough data, then a clear that ignores size and data
    send_op(stack_op(bsrpp_pkg::KIND_PUSH, 4'd3, 64'h0));
    send_op(stack_op(bsrpp_pkg::KIND_POP,  4'd4, 64'h0));
    send_op(stack_op(bsrpp_pkg::KIND_PEEK, 4'd3, 64'h0));
    send_op(stack_op(bsrpp_pkg::KIND_CLEAR, 4'd15, '1));
    send_op(stack_op(bsrpp_pkg::KIND_PEEK, 4'd1, 64'h0));

    // smallest capacity: full is checked before fit, even for size zero
    write_capacity(9'd1);
    send_op(stack_op(bsrpp_pkg::KIND_PUSH, 4'd1, 64'h5a));
    send_op(stack_op(bsrpp_pkg::KIND_PUSH, 4'd1, 64'ha5));
    send_op(stack_op(bsrpp_pkg::KIND_PUSH, 4'd0, 64'h0));
    send_op(stack_op(bsrpp_pkg::KIND_POP,  4'd1, 64'h0));
    send_op(stack_op(bsrpp_pkg::KIND_PUSH, 4'd2, 64'hffff));

    // capacity lowered under the fill level: pushes fail, reads still work
    write_capacity(9'd256);
    send_op(stack_op(bsrpp_pkg::KIND_PUSH, 4'd8, {$urandom, $urandom}));
    write_capacity(9'd5);
    send_op(stack_op(bsrpp_pkg::KIND_PUSH, 4'd1, 64'h0));
    send_op(stack_op(bsrpp_pkg::KIND_POP,  4'd4, 64'h0));
    send_op(stack_op(bsrpp_pkg::KIND_PEEK, 4'd4, 64'h0));

    // random phases; every phase starts idle, which is also the sender's drain pause
    for (int phase = 0; phase < NUM_PHASES; phase++) begin
      write_capacity(phase_caps[phase]);
      burst_mode = (phase % 4 == 2);
      if (phase == 3) begin
        // receiver stalls long while the sender sends back to back with no gaps
        burst_mode    = 1'b1;
        long_hold_req = 1'b1;
      end
      repeat (ITEMS_PER_PHASE)
        send_op(random_stack_op((phase % 2 == 1) ? 35 : 70));
    end

    in_valid  <= 1'b0;
    burst_mode = 1'b0;
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (err_count == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

endmodule

// File: sim.f
rtl/core/bsrpp_pkg.sv
rtl/core/bsrpp_ram.sv
rtl/core/bsrpp_seq.sv
rtl/core/byte_stack_record_push_pop.sv
sim/stack_result_checker.sv
sim/testbench.sv
